### rtl/ftd_pkg.sv
// shared types and constants of the float to decimal text block
`timescale 1ns / 1ps

package ftd_pkg;

    localparam int BIN_W      = 32;
    localparam int FRAC_W     = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int ND_W       = 4;
    localparam int CNT_W      = 5;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [BIN_W-1:0] SAT_INT = 32'h7FFF_FFFF;

    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [7:0] EXP_SAT      = 8'd158;
    localparam logic [7:0] EXP_UNIT     = 8'd118;
    localparam logic [7:0] RSH_LIMIT    = 8'd24;

    localparam logic [2:0] ADDR_DIGITS = 3'd0;

    typedef struct packed {
        logic              minus;
        logic              ovf;
        logic [BIN_W-1:0]  ipart;
        logic [FRAC_W-1:0] frac;
    } t_fixed;

    typedef struct packed {
        logic load;
        logic dabble;
        logic digit_shift;
        logic frac_step;
    } t_unit_ctl;

endpackage

### rtl/ftd_if.sv
// valid/ready channel interfaces for the input value and the output characters
`timescale 1ns / 1ps

interface ftd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;

    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

interface ftd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       overflow;

    modport source (output valid, output char_code, output last_char, output overflow,
                    input ready);
    modport sink   (input valid, input char_code, input last_char, input overflow,
                    output ready);
endinterface

### rtl/ftd_unpack.sv
// splits a single-precision pattern into sign, overflow, integer and fraction fixed point
`timescale 1ns / 1ps

module ftd_unpack (
    input  logic [31:0]     i_value_bits,
    output ftd_pkg::t_fixed o_fix
);

    logic        neg;
    logic [7:0]  expo;
    logic [22:0] mant;
    logic        is_nan;
    logic        is_zero;
    logic [23:0] m;
    logic [7:0]  eb;
    logic [7:0]  lsh;
    logic [7:0]  rsh;
    logic [63:0] fixed;
    logic        ovf;

    assign neg     = i_value_bits[31];
    assign expo    = i_value_bits[30:23];
    assign mant    = i_value_bits[22:0];
    assign is_nan  = (expo == ftd_pkg::EXP_ALL_ONES) && (mant != 23'd0);
    assign is_zero = (expo == 8'd0) && (mant == 23'd0);
    assign m       = {expo != 8'd0, mant};
    assign eb      = (expo != 8'd0) ? expo : 8'd1;
    assign lsh     = eb - ftd_pkg::EXP_UNIT;
    assign rsh     = ftd_pkg::EXP_UNIT - eb;
    assign ovf     = (expo == ftd_pkg::EXP_ALL_ONES) || (eb >= ftd_pkg::EXP_SAT);

    // 32 fraction bits: value times 2^32
    always_comb begin
        if (eb >= ftd_pkg::EXP_UNIT) begin
            fixed = {40'd0, m} << lsh[5:0];
        end else if (rsh >= ftd_pkg::RSH_LIMIT) begin
            fixed = 64'd0;
        end else begin
            fixed = {40'd0, m >> rsh[4:0]};
        end
    end

    always_comb begin
        o_fix.minus = neg && !is_zero && !is_nan;
        o_fix.ovf   = ovf;
        if (ovf) begin
            o_fix.ipart = ftd_pkg::SAT_INT;
            o_fix.frac  = '0;
        end else begin
            o_fix.ipart = fixed[63:32];
            o_fix.frac  = fixed[31:0];
        end
    end

endmodule

### rtl/ftd_unit.sv
// shared shift/add unit: double dabble for the integer part, times ten for the fraction
`timescale 1ns / 1ps

module ftd_unit (
    input  logic                          i_clk,
    input  ftd_pkg::t_unit_ctl            i_ctl,
    input  logic [ftd_pkg::BIN_W-1:0]     i_ipart,
    input  logic [ftd_pkg::FRAC_W-1:0]    i_frac,
    output logic [3:0]                    o_top_digit,
    output logic [3:0]                    o_frac_digit
);

    logic [ftd_pkg::BCD_W-1:0]  r_bcd;
    logic [ftd_pkg::BIN_W-1:0]  r_bin;
    logic [ftd_pkg::FRAC_W-1:0] r_frac;
    logic [ftd_pkg::BCD_W-1:0]  adj;
    logic [ftd_pkg::FRAC_W+3:0] prod;

    always_comb begin
        for (int i = 0; i < ftd_pkg::BCD_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // frac * 10 as (frac << 3) + (frac << 1)
    assign prod = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};

    assign o_top_digit  = r_bcd[ftd_pkg::BCD_W-1 -: 4];
    assign o_frac_digit = prod[ftd_pkg::FRAC_W+3 -: 4];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bcd  <= '0;
            r_bin  <= i_ipart;
            r_frac <= i_frac;
        end else begin
            if (i_ctl.dabble) begin
                {r_bcd, r_bin} <= {adj[ftd_pkg::BCD_W-2:0], r_bin, 1'b0};
            end else if (i_ctl.digit_shift) begin
                r_bcd <= {r_bcd[ftd_pkg::BCD_W-5:0], 4'd0};
            end
            if (i_ctl.frac_step) begin
                r_frac <= prod[ftd_pkg::FRAC_W-1:0];
            end
        end
    end

endmodule

### rtl/ftd_core.sv
// sequencer driving the shared unit and the character output register
`timescale 1ns / 1ps

module ftd_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ftd_pkg::ND_W-1:0]   i_nd,
    input  ftd_pkg::t_fixed            i_fix,
    ftd_in_if.sink                     i_in,
    ftd_out_if.source                  o_out
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CONV  = 7'b0000010,
        S_SKIP  = 7'b0000100,
        S_SIGN  = 7'b0001000,
        S_INT   = 7'b0010000,
        S_POINT = 7'b0100000,
        S_FRAC  = 7'b1000000
    } t_state;

    t_state                     r_state, n_state;
    logic [ftd_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_minus, n_minus;
    logic                       r_ovf, n_ovf;
    logic [ftd_pkg::ND_W-1:0]   r_nd, n_nd;
    logic                       r_out_valid, n_out_valid;
    logic [7:0]                 r_char, n_char;
    logic                       r_last, n_last;
    logic                       r_out_ovf, n_out_ovf;
    ftd_pkg::t_unit_ctl         ctl;
    logic [3:0]                 top_digit;
    logic [3:0]                 frac_digit;
    logic                       can_load;

    ftd_unit u_unit (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_ipart      (i_fix.ipart),
        .i_frac       (i_fix.frac),
        .o_top_digit  (top_digit),
        .o_frac_digit (frac_digit)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;
    assign o_out.overflow  = r_out_ovf;
    assign can_load        = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_minus     = r_minus;
        n_ovf       = r_ovf;
        n_nd        = r_nd;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_out_ovf   = r_out_ovf;
        ctl         = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    ctl.load = 1'b1;
                    n_minus  = i_fix.minus;
                    n_ovf    = i_fix.ovf;
                    n_nd     = i_nd;
                    n_cnt    = ftd_pkg::CNT_W'(ftd_pkg::BIN_W - 1);
                    n_state  = S_CONV;
                end
            end
            S_CONV: begin
                ctl.dabble = 1'b1;
                if (r_cnt == '0) begin
                    n_cnt   = ftd_pkg::CNT_W'(ftd_pkg::BCD_DIGITS - 1);
                    n_state = S_SKIP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (top_digit == 4'd0 && r_cnt != '0) begin
                    ctl.digit_shift = 1'b1;
                    n_cnt           = r_cnt - 1'b1;
                end else begin
                    n_state = r_minus ? S_SIGN : S_INT;
                end
            end
            S_SIGN: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_char      = ftd_pkg::CHAR_MINUS;
                    n_last      = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_state     = S_INT;
                end
            end
            S_INT: begin
                if (can_load) begin
                    n_out_valid     = 1'b1;
                    n_char          = ftd_pkg::CHAR_ZERO + {4'd0, top_digit};
                    n_last          = (r_cnt == '0) && (r_nd == '0);
                    n_out_ovf       = r_ovf;
                    ctl.digit_shift = 1'b1;
                    if (r_cnt == '0) begin
                        n_state = (r_nd != '0) ? S_POINT : S_IDLE;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            S_POINT: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_char      = ftd_pkg::CHAR_POINT;
                    n_last      = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_cnt       = ftd_pkg::CNT_W'(r_nd) - 1'b1;
                    n_state     = S_FRAC;
                end
            end
            S_FRAC: begin
                if (can_load) begin
                    n_out_valid   = 1'b1;
                    n_char        = ftd_pkg::CHAR_ZERO + {4'd0, frac_digit};
                    n_last        = (r_cnt == '0);
                    n_out_ovf     = r_ovf;
                    ctl.frac_step = 1'b1;
                    if (r_cnt == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_minus   <= n_minus;
        r_ovf     <= n_ovf;
        r_nd      <= n_nd;
        r_char    <= n_char;
        r_last    <= n_last;
        r_out_ovf <= n_out_ovf;
    end

endmodule

### rtl/float_to_decimal_text.sv
// top level: float to fixed-decimal ascii text with apb digit-count register
//
// One single-precision value goes in on i_in and comes out on o_out as ASCII
// characters, most significant first: an optional '-', the truncated integer
// part without leading zeros, then '.' and digits_after_point fraction digits
// (register at address 0, reset 2, values above MAX_FRAC_DIGITS act as
// MAX_FRAC_DIGITS; no '.' when it is 0). Magnitudes at or above 2^31, infinity
// and NaN print 2147483647 with a zero fraction and flag overflow on every
// character. After the accept an item goes through bit-serial binary to BCD
// conversion in the shared shift/add unit, then leading zeros are stripped,
// then one character per cycle (up to 21) goes out while o_out is ready; a new
// item is taken once the last character sits in the output register.
`timescale 1ns / 1ps

module float_to_decimal_text #(
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ftd_in_if.sink      i_in,
    ftd_out_if.source   o_out
);

    logic [ftd_pkg::ND_W-1:0] r_digits;
    logic [ftd_pkg::ND_W-1:0] nd_eff;
    logic                     wr_en;
    ftd_pkg::t_fixed          fix;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ftd_pkg::ADDR_DIGITS);
    assign prdata = (paddr == ftd_pkg::ADDR_DIGITS) ? {28'd0, r_digits} : 32'd0;
    assign nd_eff = (r_digits > ftd_pkg::ND_W'(MAX_FRAC_DIGITS))
                  ? ftd_pkg::ND_W'(MAX_FRAC_DIGITS) : r_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= 4'd2;
        end else if (wr_en) begin
            r_digits <= pwdata[ftd_pkg::ND_W-1:0];
        end
    end

    ftd_unpack u_unpack (
        .i_value_bits (i_in.value_bits),
        .o_fix        (fix)
    );

    ftd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_nd    (nd_eff),
        .i_fix   (fix),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

### tb/tb_float_to_decimal_text.sv
// testbench for float_to_decimal_text: random and corner values against a text predictor
`timescale 1ns / 1ps

module tb_float_to_decimal_text;

    localparam int         MAX_FRAC_DIGITS = 9;
    localparam int         SETTLE_CYCLES   = 80;
    localparam int         LONG_STALL      = 400;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         PRINT_CAP       = 100;
    localparam logic [2:0] ADDR_UNUSED     = 3'd4;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       ovf;
    } t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ftd_in_if  in_if ();
    ftd_out_if out_if ();

    float_to_decimal_text #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #2 i_clk = ~i_clk;

    logic [31:0] value_queue[$];
    t_char       expected_chars[$];
    logic [3:0]  digit_cfg;
    logic        quiet;
    logic        long_stall_req;
    logic        long_stall_done;
    int          mismatches = 0;
    int          src_gap;
    int          sink_gap;
    int          idle_cycles = 0;
    t_char       seen_char;
    t_char       want_char;

    task automatic report_error(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic void push_char(input logic [7:0] code, input logic ovf);
        t_char ch;
        ch.code = code;
        ch.last = 1'b0;
        ch.ovf  = ovf;
        expected_chars.push_back(ch);
    endfunction

    task automatic predict_text(input logic [31:0] bits);
        logic        neg;
        logic        is_nan;
        logic        is_zero;
        logic        ovf;
        logic [7:0]  expo;
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] fd;
        logic [63:0] scale;
        logic [31:0] ipart;
        logic [3:0]  digs[10];
        int          e;
        int          sh;
        int          nd;
        int          ndig;
        int          k;
        t_char       ch;
        neg     = bits[31];
        expo    = bits[30:23];
        mant    = {40'd0, (expo != 8'd0), bits[22:0]};
        is_nan  = (expo == ftd_pkg::EXP_ALL_ONES) && (bits[22:0] != 23'd0);
        is_zero = (expo == 8'd0) && (bits[22:0] == 23'd0);
        ovf     = 1'b0;
        ipart   = '0;
        frac    = '0;
        nd      = (int'(digit_cfg) > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : int'(digit_cfg);
        e       = ((expo != 8'd0) ? int'(expo) : 1) - 150;
        if (expo == ftd_pkg::EXP_ALL_ONES || e >= 8) begin
            ovf = 1'b1;
        end else if (e >= 0) begin
            ipart = mant[31:0] << e;
        end else begin
            sh = -e;
            if (sh < 24) begin
                ipart = mant[31:0] >> sh;
            end
            if (sh <= 32) begin
                frac = (mant & ((64'd1 << sh) - 64'd1)) << (32 - sh);
            end else if (sh - 32 < 24) begin
                frac = mant >> (sh - 32);
            end
        end
        if (ovf) begin
            ipart = ftd_pkg::SAT_INT;
            frac  = '0;
        end
        if (neg && !is_zero && !is_nan) begin
            push_char(ftd_pkg::CHAR_MINUS, ovf);
        end
        ndig = 0;
        do begin
            digs[ndig] = 4'(ipart % 10);
            ipart      = ipart / 10;
            ndig++;
        end while (ipart != 0);
        for (k = ndig - 1; k >= 0; k--) begin
            push_char(ftd_pkg::CHAR_ZERO + digs[k], ovf);
        end
        if (nd != 0) begin
            scale = 64'd1;
            for (k = 0; k < nd; k++) begin
                scale = scale * 10;
            end
            fd = (frac * scale) >> 32;
            for (k = nd - 1; k >= 0; k--) begin
                digs[k] = 4'(fd % 10);
                fd      = fd / 10;
            end
            push_char(ftd_pkg::CHAR_POINT, ovf);
            for (k = 0; k < nd; k++) begin
                push_char(ftd_pkg::CHAR_ZERO + digs[k], ovf);
            end
        end
        ch      = expected_chars.pop_back();
        ch.last = 1'b1;
        expected_chars.push_back(ch);
    endtask

    function automatic logic [31:0] random_value();
        int          pick;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        v    = $urandom;
        if (pick < 50) begin
            v[30:23] = 8'($urandom_range(110, 160));
        end else if (pick < 60) begin
            v[30:23] = 8'($urandom_range(0, 3));
        end else if (pick < 75) begin
            case ($urandom_range(0, 3))
                0: begin
                    v[30:0] = '0;
                end
                1: begin
                    v[30:0] = {ftd_pkg::EXP_ALL_ONES, 23'd0};
                end
                2: begin
                    v[30:23] = ftd_pkg::EXP_ALL_ONES;
                end
                default: begin
                    v[30:23] = 8'($urandom_range(156, 159));
                end
            endcase
        end
        return v;
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ftd_pkg::ADDR_DIGITS) begin
            digit_cfg = data[ftd_pkg::ND_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (value_queue.size() != 0 || in_if.valid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) value_queue.push_back(random_value());
        drain();
    endtask

    task automatic set_digits(input logic [3:0] nd);
        logic [31:0] word;
        word      = $urandom;
        word[3:0] = nd;
        apb_write(ftd_pkg::ADDR_DIGITS, word);
    endtask

    // value driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_text(value_queue.pop_front());
            end
            if (!in_if.valid || in_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (!quiet && $urandom_range(0, 2) == 0) begin
                    src_gap = $urandom_range(1, 13);
                end
                if (src_gap == 0 && value_queue.size() != 0) begin
                    in_if.valid      <= 1'b1;
                    in_if.value_bits <= value_queue[0];
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // character monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            sink_gap = 0;
            long_stall_done = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                seen_char = {out_if.char_code, out_if.last_char, out_if.overflow};
                if (expected_chars.size() == 0) begin
                    report_error($sformatf("unexpected char %h last %b ovf %b",
                                           seen_char.code, seen_char.last, seen_char.ovf));
                end else begin
                    want_char = expected_chars.pop_front();
                    if (seen_char != want_char) begin
                        report_error($sformatf("char %h/%h last %b/%b ovf %b/%b (got/exp)",
                                               seen_char.code, want_char.code,
                                               seen_char.last, want_char.last,
                                               seen_char.ovf, want_char.ovf));
                    end
                end
            end
            if (long_stall_req && !long_stall_done) begin
                sink_gap        = LONG_STALL;
                long_stall_done = 1'b1;
            end
            if (sink_gap > 0) begin
                sink_gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 13);
            end
            out_if.ready <= (sink_gap == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        in_if.valid      = 1'b0;
        in_if.value_bits = '0;
        out_if.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_rst_n          = 1'b0;
        quiet            = 1'b0;
        long_stall_req   = 1'b0;
        digit_cfg        = 4'd2;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zeros, signs, unit values, saturation edge, inf, nan, subnormals
        value_queue = '{
            32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
            32'h3F00_0000, 32'hBA83_126F, 32'h4F00_0000, 32'h4EFF_FFFF,
            32'hCF00_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
            32'hFFC0_0001, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000,
            32'h3F7F_FFFF, 32'h4049_0FDB, 32'h42F6_E979, 32'h4B7F_FFFF,
            32'h4B00_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF
        };
        drain();

        set_digits(4'd0);
        run_random(40);
        set_digits(4'd9);
        run_random(60);
        set_digits(4'd15);
        long_stall_req = 1'b1;
        run_random(30);
        apb_write(ADDR_UNUSED, 32'h0000_0005);
        run_random(40);
        set_digits(4'd1);
        run_random(40);
        set_digits(4'd5);
        run_random(60);
        set_digits(4'($urandom_range(0, 15)));
        run_random(60);
        quiet = 1'b1;
        set_digits(4'd3);
        run_random(50);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
